// ===== rtl/core/drpwa_pkg.sv =====
// Shared types and constants for the dirty rectangle to panel window aligner.
// Used by the top level and by its port checker; depends on nothing else.
`default_nettype none

package drpwa_pkg;

    // Default panel geometry in pixels.
    localparam int PANEL_WIDTH_DEF  = 368;
    localparam int PANEL_HEIGHT_DEF = 448;

    // Working width of the signed window arithmetic; wide enough for any
    // panel up to 2048 by 2048 and any 12-bit signed coordinates.
    localparam int CALC_W  = 16;
    localparam int COORD_W = 12;

    // Rectangle forms selected by op.
    localparam logic OP_PORTRAIT  = 1'b0;
    localparam logic OP_LANDSCAPE = 1'b1;

    typedef struct packed {
        logic                      op;
        logic signed [COORD_W-1:0] coord_a;
        logic signed [COORD_W-1:0] coord_b;
        logic signed [COORD_W-1:0] coord_c;
        logic signed [COORD_W-1:0] coord_d;
    } rect_in_t;

    typedef struct packed {
        logic        push_valid;
        logic [8:0]  win_x_start;
        logic [10:0] win_y_start;
        logic [8:0]  win_x_end;
        logic [11:0] win_y_end;
    } win_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/dirty_rect_push_window_align.sv =====
// Throughput: one rectangle per cycle while the consumer keeps m_ready high; an
// input register feeds the window arithmetic, which loads a result register.
// Each stage holds its item while the stage after it is stalled; an empty input
// stage still takes a rectangle while the result register is stalled.
// Reset: aresetn, synchronous and active low, empties both stages.
// Holds the top level; depends on drpwa_pkg.
`default_nettype none

module dirty_rect_push_window_align #(
    parameter int PANEL_WIDTH  = drpwa_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = drpwa_pkg::PANEL_HEIGHT_DEF
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  drpwa_pkg::rect_in_t   s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output drpwa_pkg::win_out_t   m_data
);

    localparam int CW = drpwa_pkg::CALC_W;
    localparam int XW = drpwa_pkg::COORD_W;

    localparam logic signed [CW-1:0] PW_S    = CW'(PANEL_WIDTH);
    localparam logic signed [CW-1:0] PH_S    = CW'(PANEL_HEIGHT);
    localparam logic signed [CW-1:0] ZERO_S  = CW'(0);
    localparam logic signed [CW-1:0] ONE_S   = CW'(1);
    localparam logic signed [CW-1:0] TWO_S   = CW'(2);
    localparam logic signed [CW-1:0] SEVEN_S = CW'(7);
    localparam logic signed [CW-1:0] EIGHT_S = CW'(8);

    // Pipeline registers.
    logic                in_valid_reg, in_valid_next;
    drpwa_pkg::rect_in_t in_data_reg,  in_data_next;
    logic                out_valid_reg, out_valid_next;
    drpwa_pkg::win_out_t out_data_reg,  out_data_next;

    logic out_ready;

    // Window arithmetic.
    logic signed [CW-1:0] a_s, b_s, c_s, d_s;
    logic signed [CW-1:0] min_x, min_y, max_x, max_y;
    logic signed [CW-1:0] cmin_x, cmin_y, cmax_x, cmax_y;
    logic signed [CW-1:0] x0_a, w_raw, w_rnd, x1_a;
    logic signed [CW-1:0] x0_b, x0_c, w_c, x0_d, x1_d, x0_e, x1_e;
    logic signed [CW-1:0] x0_f, x1_f;
    logic signed [CW-1:0] y0, y1_a, y1_b, y1_c, y1_f;
    logic                 empty_rect, slide;

    assign out_ready = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            in_data_next  = s_data;
        end
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_comb begin
        a_s = {{(CW-XW){in_data_reg.coord_a[XW-1]}}, in_data_reg.coord_a};
        b_s = {{(CW-XW){in_data_reg.coord_b[XW-1]}}, in_data_reg.coord_b};
        c_s = {{(CW-XW){in_data_reg.coord_c[XW-1]}}, in_data_reg.coord_c};
        d_s = {{(CW-XW){in_data_reg.coord_d[XW-1]}}, in_data_reg.coord_d};

        // Landscape rectangles are rotated a quarter turn into panel space.
        if (in_data_reg.op == drpwa_pkg::OP_LANDSCAPE) begin
            min_x = PW_S - (b_s + d_s);
            max_x = PW_S - b_s - ONE_S;
            min_y = a_s;
            max_y = a_s + c_s - ONE_S;
        end else begin
            min_x = a_s;
            max_x = c_s;
            min_y = b_s;
            max_y = d_s;
        end
        empty_rect = (min_x > max_x) || (min_y > max_y);

        // Only the start is clamped at zero and only the end at the panel edge.
        cmin_x = (min_x < ZERO_S) ? ZERO_S : min_x;
        cmin_y = (min_y < ZERO_S) ? ZERO_S : min_y;
        cmax_x = (max_x > PW_S - ONE_S) ? PW_S - ONE_S : max_x;
        cmax_y = (max_y > PH_S - ONE_S) ? PH_S - ONE_S : max_y;

        // Columns: even start, length rounded up to a multiple of eight.
        x0_a  = {cmin_x[CW-1:1], 1'b0};
        w_raw = cmax_x + ONE_S - x0_a;
        w_rnd = (w_raw <= EIGHT_S) ? EIGHT_S : ((w_raw + SEVEN_S) & ~SEVEN_S);
        x1_a  = x0_a + w_rnd;
        slide = x1_a > PW_S;

        // A window past the right edge is moved left, keeping its width when it fits.
        x0_b = PW_S - w_rnd;
        x0_c = (x0_b < ZERO_S) ? ZERO_S : x0_b;
        w_c  = (x0_b < ZERO_S) ? PW_S : w_rnd;
        x0_d = {x0_c[CW-1:1], 1'b0};
        x1_d = x0_d + w_c;
        x0_e = (x1_d > PW_S) ? PW_S - w_c : x0_d;
        x1_e = (x1_d > PW_S) ? PW_S : x1_d;
        x0_f = slide ? x0_e : x0_a;
        x1_f = slide ? x1_e : x1_a;

        // Rows: even start, end rounded up to even, at least two rows.
        y0   = {cmin_y[CW-1:1], 1'b0};
        y1_a = cmax_y + ONE_S;
        y1_b = y1_a + {{(CW-1){1'b0}}, y1_a[0]};
        y1_c = (y1_b > PH_S) ? PH_S : y1_b;
        y1_f = (y1_c <= y0) ? y0 + TWO_S : y1_c;

        out_data_next = out_data_reg;
        if (out_ready) begin
            if (empty_rect) begin
                out_data_next = '0;
            end else begin
                out_data_next.push_valid  = 1'b1;
                out_data_next.win_x_start = x0_f[8:0];
                out_data_next.win_y_start = y0[10:0];
                out_data_next.win_x_end   = x1_f[8:0];
                out_data_next.win_y_end   = y1_f[11:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/drpwa_port_check.sv =====
// Port-level checks for dirty_rect_push_window_align, bound to the top level.
// Depends on drpwa_pkg and the top level's port list.
`default_nettype none

module drpwa_port_check (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_valid,
    input wire                 s_ready,
    input wire                 m_valid,
    input wire                 m_ready,
    input drpwa_pkg::win_out_t m_data
);

    // A result held back by the consumer keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // A result only appears after a matching input transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a matching input transfer");

    // A rejected rectangle carries an all-zero window.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.push_valid |->
            m_data.win_x_start == '0 && m_data.win_y_start == '0 &&
            m_data.win_x_end == '0 && m_data.win_y_end == '0)
        else $error("rejected rectangle with nonzero window");

    // Pushed windows start on an even row and span a multiple of eight columns.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.push_valid |->
            !m_data.win_y_start[0] &&
            m_data.win_x_end[2:0] == m_data.win_x_start[2:0])
        else $error("window misaligned");

    // Nothing is offered in the first cycle after reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result offered right after reset");

endmodule

bind dirty_rect_push_window_align drpwa_port_check u_drpwa_port_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
